// ===== src/mqr_pkg.sv =====
// ----------------------------------------------------------------------------
// mqr_pkg
// Shared types and constants of the multi-queue ring FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mqr_pkg;

    // default sizes
    localparam int NUM_QUEUES_DEF  = 4;
    localparam int MAX_LENGTH_DEF  = 256;
    localparam int ENTRY_WIDTH_DEF = 32;

    // fixed port widths
    localparam int CMD_W       = 3;
    localparam int QID_PORT_W  = 3;
    localparam int DATA_W      = 32;
    localparam int WIDE_W      = 64;
    localparam int ERR_W       = 2;
    localparam int FILL_W      = 2;
    localparam int CNT_W       = 8;
    localparam int CNT_MAX     = 255;

    // length registers
    localparam int NUM_LEN_REGS = 4;
    localparam int LEN_SEL_W    = 2;
    localparam int LEN_REG_W    = 9;
    localparam int CFG_INDEX_W  = 3;
    localparam logic [LEN_REG_W-1:0] LEN_RESET = 9'd256;
    localparam int MIN_LENGTH   = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

    // fill states
    localparam logic [FILL_W-1:0] FILL_EMPTY = 2'd0;
    localparam logic [FILL_W-1:0] FILL_READY = 2'd1;
    localparam logic [FILL_W-1:0] FILL_FULL  = 2'd2;

    // response bookkeeping handed from the controller to the output stage
    typedef struct packed {
        logic                valid;
        logic                rd_sel;
        logic [ERR_W-1:0]    err;
        logic [FILL_W-1:0]   fill;
        logic [CNT_W-1:0]    cnt;
    } rsp_t;

endpackage

// ===== src/mqr_ram.sv =====
// ----------------------------------------------------------------------------
// mqr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mqr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqr_ctrl
// Queue controller: length registers, ring indices, command decode and
// entry store request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqr_ctrl #(
    parameter int NUM_QUEUES  = mqr_pkg::NUM_QUEUES_DEF,
    parameter int MAX_LENGTH  = mqr_pkg::MAX_LENGTH_DEF,
    parameter int ENTRY_WIDTH = mqr_pkg::ENTRY_WIDTH_DEF,
    parameter int ADDR_W      = ((NUM_QUEUES * MAX_LENGTH) > 1)
                                ? $clog2(NUM_QUEUES * MAX_LENGTH) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [mqr_pkg::CMD_W-1:0]          command,
    input  logic [mqr_pkg::QID_PORT_W-1:0]     queue_id,
    input  logic [mqr_pkg::DATA_W-1:0]         write_value,
    input  logic                               cfg_we,
    input  logic [mqr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mqr_pkg::LEN_REG_W-1:0]      cfg_data,
    output logic                               mem_we,
    output logic [ADDR_W-1:0]                  mem_addr,
    output logic [ENTRY_WIDTH-1:0]             mem_wdata,
    output mqr_pkg::rsp_t                      rsp
);

    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int QID_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int RAW_W = (LEN_W > mqr_pkg::LEN_REG_W) ? LEN_W : mqr_pkg::LEN_REG_W;

    logic [mqr_pkg::LEN_REG_W-1:0] len_reg [mqr_pkg::NUM_LEN_REGS];
    logic [IDX_W-1:0] rd_idx_reg [NUM_QUEUES];
    logic [IDX_W-1:0] wr_idx_reg [NUM_QUEUES];
    mqr_pkg::rsp_t    rsp_reg;
    mqr_pkg::rsp_t    rsp_next;

    logic                           q_valid;
    logic [QID_W-1:0]               qsel;
    logic [RAW_W-1:0]               len_raw;
    logic [LEN_W-1:0]               len;
    logic [IDX_W-1:0]               g_idx;
    logic [IDX_W-1:0]               p_idx;
    logic [IDX_W-1:0]               ng_idx;
    logic [IDX_W-1:0]               np_idx;
    logic                           is_empty;
    logic                           is_full;
    logic [LEN_W-1:0]               count;
    logic [ADDR_W-1:0]              base;
    logic [mqr_pkg::WIDE_W-1:0]     wval_wide;
    logic                           upd_rd;
    logic                           upd_wr;
    logic                           do_flush;

    assign q_valid = (32'(queue_id) < NUM_QUEUES);
    assign qsel    = QID_W'(queue_id);
    assign g_idx   = rd_idx_reg[qsel];
    assign p_idx   = wr_idx_reg[qsel];

    always_comb
    begin
        if (32'(queue_id) < mqr_pkg::NUM_LEN_REGS)
        begin
            len_raw = RAW_W'(len_reg[queue_id[mqr_pkg::LEN_SEL_W-1:0]]);
        end
        else
        begin
            len_raw = RAW_W'(MAX_LENGTH);
        end
        if (32'(len_raw) > MAX_LENGTH)
        begin
            len = LEN_W'(MAX_LENGTH);
        end
        else if (32'(len_raw) < mqr_pkg::MIN_LENGTH)
        begin
            len = LEN_W'(mqr_pkg::MIN_LENGTH);
        end
        else
        begin
            len = LEN_W'(len_raw);
        end
    end

    // indices stay inside the ring: a length write flushes the queue
    always_comb
    begin
        if ((LEN_W'(g_idx) + LEN_W'(1)) >= len)
        begin
            ng_idx = '0;
        end
        else
        begin
            ng_idx = g_idx + IDX_W'(1);
        end
        if ((LEN_W'(p_idx) + LEN_W'(1)) >= len)
        begin
            np_idx = '0;
        end
        else
        begin
            np_idx = p_idx + IDX_W'(1);
        end
    end

    assign is_empty = (ng_idx == p_idx);
    assign is_full  = (p_idx == g_idx);

    always_comb
    begin
        if (p_idx > g_idx)
        begin
            count = LEN_W'(p_idx) - LEN_W'(g_idx) - LEN_W'(1);
        end
        else
        begin
            count = LEN_W'(p_idx) + len - LEN_W'(g_idx) - LEN_W'(1);
        end
    end

    assign base      = ADDR_W'(32'(qsel) * MAX_LENGTH);
    assign wval_wide = mqr_pkg::WIDE_W'(write_value);

    always_comb
    begin
        rsp_next       = '0;
        rsp_next.valid = accept;
        mem_we         = 1'b0;
        mem_addr       = base + ADDR_W'(ng_idx);
        mem_wdata      = wval_wide[ENTRY_WIDTH-1:0];
        upd_rd         = 1'b0;
        upd_wr         = 1'b0;
        do_flush       = 1'b0;
        if (command > mqr_pkg::CMD_FLUSH)
        begin
            // unknown command: all-zero word, no effect
        end
        else if (!q_valid)
        begin
            rsp_next.err = mqr_pkg::ERR_RANGE;
        end
        else
        begin
            case (command)
                mqr_pkg::CMD_PUT:
                begin
                    mem_addr = base + ADDR_W'(p_idx);
                    if (is_full)
                    begin
                        rsp_next.err = mqr_pkg::ERR_FULL;
                    end
                    else
                    begin
                        mem_we = accept;
                        upd_wr = accept;
                    end
                end
                mqr_pkg::CMD_GET:
                begin
                    if (is_empty)
                    begin
                        rsp_next.err = mqr_pkg::ERR_EMPTY;
                    end
                    else
                    begin
                        rsp_next.rd_sel = 1'b1;
                        upd_rd          = accept;
                    end
                end
                mqr_pkg::CMD_STATUS:
                begin
                    if (is_empty)
                    begin
                        rsp_next.fill = mqr_pkg::FILL_EMPTY;
                    end
                    else if (is_full)
                    begin
                        rsp_next.fill = mqr_pkg::FILL_FULL;
                    end
                    else
                    begin
                        rsp_next.fill = mqr_pkg::FILL_READY;
                    end
                end
                mqr_pkg::CMD_COUNT:
                begin
                    if (32'(count) > mqr_pkg::CNT_MAX)
                    begin
                        rsp_next.cnt = mqr_pkg::CNT_W'(mqr_pkg::CNT_MAX);
                    end
                    else
                    begin
                        rsp_next.cnt = mqr_pkg::CNT_W'(count);
                    end
                end
                mqr_pkg::CMD_FLUSH:
                begin
                    do_flush = accept;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mqr_pkg::NUM_LEN_REGS; i++)
            begin
                len_reg[i] <= mqr_pkg::LEN_RESET;
            end
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                rd_idx_reg[q] <= '0;
                wr_idx_reg[q] <= IDX_W'(1);
            end
            rsp_reg <= '0;
        end
        else
        begin
            rsp_reg <= rsp_next;
            if (cfg_we)
            begin
                // a length write also flushes its queue
                for (int i = 0; i < mqr_pkg::NUM_LEN_REGS; i++)
                begin
                    if (32'(cfg_index) == i)
                    begin
                        len_reg[i] <= cfg_data;
                    end
                end
                for (int q = 0; q < NUM_QUEUES; q++)
                begin
                    if (32'(cfg_index) == q && q < mqr_pkg::NUM_LEN_REGS)
                    begin
                        rd_idx_reg[q] <= '0;
                        wr_idx_reg[q] <= IDX_W'(1);
                    end
                end
            end
            else
            begin
                if (do_flush)
                begin
                    rd_idx_reg[qsel] <= '0;
                    wr_idx_reg[qsel] <= IDX_W'(1);
                end
                if (upd_rd)
                begin
                    rd_idx_reg[qsel] <= ng_idx;
                end
                if (upd_wr)
                begin
                    wr_idx_reg[qsel] <= np_idx;
                end
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== src/multi_queue_ring_fifo_top.sv =====
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo_top
// Several ring-buffer FIFOs sharing one entry store, driven by commands.
//
//   channel   signals                                      direction
//   command   start, busy, command, queue_id, write_value  in (busy out)
//   result    done, read_value, error_code, fill_state,    out
//             entry_count
//   config    cfg_we, cfg_index, cfg_data                  in
//
// One command per cycle while busy is low; its result word appears with done in the
// cycle after acceptance, set by the registered read of the entry store.
// busy is high during reset and until the ready register is first set after it, then stays low.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_ring_fifo_top #(
    parameter int NUM_QUEUES  = mqr_pkg::NUM_QUEUES_DEF,
    parameter int MAX_LENGTH  = mqr_pkg::MAX_LENGTH_DEF,
    parameter int ENTRY_WIDTH = mqr_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mqr_pkg::CMD_W-1:0]          command,
    input  logic [mqr_pkg::QID_PORT_W-1:0]     queue_id,
    input  logic [mqr_pkg::DATA_W-1:0]         write_value,
    input  logic                               cfg_we,
    input  logic [mqr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mqr_pkg::LEN_REG_W-1:0]      cfg_data,
    output logic                               done,
    output logic [mqr_pkg::DATA_W-1:0]         read_value,
    output logic [mqr_pkg::ERR_W-1:0]          error_code,
    output logic [mqr_pkg::FILL_W-1:0]         fill_state,
    output logic [mqr_pkg::CNT_W-1:0]          entry_count
);

    localparam int DEPTH  = NUM_QUEUES * MAX_LENGTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                       ready_reg;
    logic                       accept;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_addr;
    logic [ENTRY_WIDTH-1:0]     mem_wdata;
    logic [ENTRY_WIDTH-1:0]     mem_rdata;
    logic [mqr_pkg::WIDE_W-1:0] rdata_wide;
    mqr_pkg::rsp_t              rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
        end
    end

    assign busy   = ~ready_reg;
    assign accept = start & ready_reg;

    mqr_ctrl #(
        .NUM_QUEUES  (NUM_QUEUES),
        .MAX_LENGTH  (MAX_LENGTH),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .queue_id    (queue_id),
        .write_value (write_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .rsp         (rsp)
    );

    mqr_ram #(
        .WIDTH  (ENTRY_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // read data lines up with the registered response
    assign rdata_wide  = mqr_pkg::WIDE_W'(mem_rdata);
    assign done        = rsp.valid;
    assign read_value  = rsp.rd_sel ? rdata_wide[mqr_pkg::DATA_W-1:0] : '0;
    assign error_code  = rsp.err;
    assign fill_state  = rsp.fill;
    assign entry_count = rsp.cnt;

endmodule
